// ===== rtl/core/vector_distance_accumulator_core_macros.svh =====
// Assertion macros used by the vector distance accumulator checker.
`ifndef VECTOR_DISTANCE_ACCUMULATOR_CORE_MACROS_SVH
`define VECTOR_DISTANCE_ACCUMULATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define VDA_ASSERT_IMPL(label, cond, consequent, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (consequent)) else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define VDA_ASSERT_NEXT(label, cond, consequent, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (consequent)) else $error(msg);

`endif

// ===== rtl/core/vda_pkg.sv =====
// Shared constants and request types of the vector distance accumulator.
`timescale 1ns / 1ps

package vda_pkg;

    localparam int LANES      = 4;
    localparam int IN_LANES   = 4;
    localparam int EFF_LANES  = (LANES < IN_LANES) ? LANES : IN_LANES;
    localparam int ELEM_W     = 16;
    localparam int LANE_CNT_W = 3;
    localparam int MAX_DIM    = 4096;
    localparam int CNT_W      = $clog2(MAX_DIM + 1);
    localparam int ACC_W      = 48;
    localparam int PROD_W     = 2 * ELEM_W + 2;
    localparam int ISUM_W     = PROD_W + $clog2(IN_LANES);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic {
        MODE_INNER = 1'b0,
        MODE_L2    = 1'b1
    } metric_t;

    // One accepted request, lane count already clamped.
    typedef struct packed {
        logic [IN_LANES-1:0][ELEM_W-1:0] a;
        logic [IN_LANES-1:0][ELEM_W-1:0] b;
        logic [LANE_CNT_W-1:0]           lanes;
        logic                            last;
        metric_t                         mode;
    } lane_req_t;

    // Exact sum of one request's lane terms.
    typedef struct packed {
        logic [ISUM_W-1:0]     sum;
        logic [LANE_CNT_W-1:0] lanes;
        logic                  last;
        metric_t               mode;
    } item_req_t;

endpackage

// ===== rtl/core/vda_item_sum.sv =====
// Lane multipliers and the per-request sum, two registered stages.
`timescale 1ns / 1ps

module vda_item_sum (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  vda_pkg::lane_req_t in_req,
    output logic               in_ready,
    output logic               out_valid,
    output vda_pkg::item_req_t out_item,
    input  logic               out_ready
);
    import vda_pkg::*;

    logic signed [ELEM_W:0]   op_x [IN_LANES];
    logic signed [ELEM_W:0]   op_y [IN_LANES];
    logic signed [PROD_W-1:0] prod_next [IN_LANES];
    logic signed [PROD_W-1:0] prod_reg [IN_LANES];
    logic [LANE_CNT_W-1:0]    p_lanes_reg;
    logic                     p_last_reg;
    metric_t                  p_mode_reg;
    logic                     p_valid_reg;
    logic                     p_ready;
    logic                     s_valid_reg;
    logic                     s_ready;
    logic signed [ISUM_W-1:0] sum_next;
    item_req_t                item_reg;

    assign s_ready  = !s_valid_reg || out_ready;
    assign p_ready  = !p_valid_reg || s_ready;
    assign in_ready = p_ready;

    // One multiplier per lane: a*b, or (a-b)*(a-b) for the L2 metric.
    always_comb
    begin
        for (int i = 0; i < IN_LANES; i++)
        begin
            if (in_req.mode == MODE_L2)
            begin
                op_x[i] = $signed({in_req.a[i][ELEM_W-1], in_req.a[i]})
                        - $signed({in_req.b[i][ELEM_W-1], in_req.b[i]});
                op_y[i] = op_x[i];
            end
            else
            begin
                op_x[i] = $signed({in_req.a[i][ELEM_W-1], in_req.a[i]});
                op_y[i] = $signed({in_req.b[i][ELEM_W-1], in_req.b[i]});
            end
            if (LANE_CNT_W'(i) < in_req.lanes)
            begin
                prod_next[i] = PROD_W'(op_x[i] * op_y[i]);
            end
            else
            begin
                prod_next[i] = '0;
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < IN_LANES; i++)
        begin
            sum_next = sum_next + ISUM_W'(prod_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_ready)
            begin
                p_valid_reg <= in_valid;
            end
            if (s_ready)
            begin
                s_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && p_ready)
        begin
            for (int i = 0; i < IN_LANES; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            p_lanes_reg <= in_req.lanes;
            p_last_reg  <= in_req.last;
            p_mode_reg  <= in_req.mode;
        end
        if (p_valid_reg && s_ready)
        begin
            item_reg.sum   <= sum_next;
            item_reg.lanes <= p_lanes_reg;
            item_reg.last  <= p_last_reg;
            item_reg.mode  <= p_mode_reg;
        end
    end

    assign out_valid = s_valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/core/vda_accum.sv =====
// Saturating accumulator, element counter and the registered result stage.
`timescale 1ns / 1ps

module vda_accum (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  vda_pkg::item_req_t                in_item,
    output logic                              in_ready,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [vda_pkg::ACC_W-1:0]  distance,
    output logic                              saturated,
    output logic [vda_pkg::CNT_W-1:0]         element_count
);
    import vda_pkg::*;

    logic signed [ACC_W-1:0] acc_reg;
    logic                    clip_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [ACC_W:0]   wide_sum;
    logic                    hit;
    logic signed [ACC_W-1:0] acc_next;
    logic [CNT_W:0]          cnt_wide;
    logic [CNT_W-1:0]        cnt_next;
    logic                    fire;

    logic                    fin_valid_reg;
    logic signed [ACC_W-1:0] fin_sum_reg;
    logic                    fin_clip_reg;
    logic [CNT_W-1:0]        fin_cnt_reg;
    metric_t                 fin_mode_reg;
    logic                    fin_ready;
    logic                    fin_is_min;
    logic signed [ACC_W-1:0] dist_next;
    logic                    sat_next;

    logic                    out_valid_reg;
    logic                    out_ready;
    logic signed [ACC_W-1:0] dist_reg;
    logic                    sat_reg;
    logic [CNT_W-1:0]        count_reg;

    assign out_ready = !out_valid_reg || !result_stall;
    assign fin_ready = !fin_valid_reg || out_ready;
    // Only a closing request needs room in the result stage.
    assign in_ready  = !in_item.last || fin_ready;
    assign fire      = in_valid && in_ready;

    // One extra bit shows overflow; the item sum is added in a single step.
    always_comb
    begin
        wide_sum = $signed({acc_reg[ACC_W-1], acc_reg})
                 + $signed((ACC_W+1)'($signed(in_item.sum)));
        hit = (wide_sum[ACC_W] != wide_sum[ACC_W-1]);
        if (!hit)
        begin
            acc_next = wide_sum[ACC_W-1:0];
        end
        else if (wide_sum[ACC_W])
        begin
            acc_next = ACC_MIN;
        end
        else
        begin
            acc_next = ACC_MAX;
        end
        cnt_wide = {1'b0, cnt_reg} + (CNT_W+1)'(in_item.lanes);
        if (cnt_wide > (CNT_W+1)'(MAX_DIM))
        begin
            cnt_next = CNT_W'(MAX_DIM);
        end
        else
        begin
            cnt_next = cnt_wide[CNT_W-1:0];
        end
    end

    // Negating the most negative sum clips and marks the result saturated.
    always_comb
    begin
        fin_is_min = (fin_sum_reg == ACC_MIN);
        if (fin_mode_reg == MODE_INNER)
        begin
            dist_next = fin_is_min ? ACC_MAX : -fin_sum_reg;
            sat_next  = fin_clip_reg || fin_is_min;
        end
        else
        begin
            dist_next = fin_sum_reg;
            sat_next  = fin_clip_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            clip_reg      <= 1'b0;
            cnt_reg       <= '0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                if (in_item.last)
                begin
                    acc_reg  <= '0;
                    clip_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    acc_reg  <= acc_next;
                    clip_reg <= clip_reg || hit;
                    cnt_reg  <= cnt_next;
                end
            end
            if (fin_ready)
            begin
                fin_valid_reg <= fire && in_item.last;
            end
            if (out_ready)
            begin
                out_valid_reg <= fin_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_item.last)
        begin
            fin_sum_reg  <= acc_next;
            fin_clip_reg <= clip_reg || hit;
            fin_cnt_reg  <= cnt_next;
            fin_mode_reg <= in_item.mode;
        end
        if (fin_valid_reg && out_ready)
        begin
            dist_reg  <= dist_next;
            sat_reg   <= sat_next;
            count_reg <= fin_cnt_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign distance      = dist_reg;
    assign saturated     = sat_reg;
    assign element_count = count_reg;

endmodule

// ===== rtl/core/vector_distance_accumulator_core.sv =====
// Top level of the vector distance accumulator: input register and stage wiring.
//
//   Channel   Direction  Handshake               Payload
//   config    in         cfg_wr_en               cfg_wr_data (metric_mode)
//   item      in         item_valid, item_stall  a_lane0..3, b_lane0..3, lanes_used,
//                                                last_item
//   result    out        result_valid, result_stall  distance, saturated,
//                                                element_count
//
// One request is taken per cycle while item_stall is low; acc_reg alone sits in the
// accumulator loop. A closing request passes the product, sum and final registers to
// the output register. Reset clears the accumulator, clip flag, element count and
// metric mode. The stages advance independently, so the input keeps moving while a
// result waits; requests stall only once every stage in front of them is full.
`timescale 1ns / 1ps

module vector_distance_accumulator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic signed [vda_pkg::ELEM_W-1:0]   a_lane0,
    input  logic signed [vda_pkg::ELEM_W-1:0]   a_lane1,
    input  logic signed [vda_pkg::ELEM_W-1:0]   a_lane2,
    input  logic signed [vda_pkg::ELEM_W-1:0]   a_lane3,
    input  logic signed [vda_pkg::ELEM_W-1:0]   b_lane0,
    input  logic signed [vda_pkg::ELEM_W-1:0]   b_lane1,
    input  logic signed [vda_pkg::ELEM_W-1:0]   b_lane2,
    input  logic signed [vda_pkg::ELEM_W-1:0]   b_lane3,
    input  logic [vda_pkg::LANE_CNT_W-1:0]      lanes_used,
    input  logic                                last_item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [vda_pkg::ACC_W-1:0]    distance,
    output logic                                saturated,
    output logic [vda_pkg::CNT_W-1:0]           element_count
);
    import vda_pkg::*;

    metric_t   mode_reg;
    logic      in_valid_reg;
    lane_req_t in_req_reg;
    lane_req_t in_req_next;
    logic      sum_ready;
    logic      item_valid_s;
    item_req_t item_s;
    logic      acc_ready;

    always_comb
    begin
        in_req_next.a[0] = a_lane0;
        in_req_next.a[1] = a_lane1;
        in_req_next.a[2] = a_lane2;
        in_req_next.a[3] = a_lane3;
        in_req_next.b[0] = b_lane0;
        in_req_next.b[1] = b_lane1;
        in_req_next.b[2] = b_lane2;
        in_req_next.b[3] = b_lane3;
        if (lanes_used > LANE_CNT_W'(EFF_LANES))
        begin
            in_req_next.lanes = LANE_CNT_W'(EFF_LANES);
        end
        else
        begin
            in_req_next.lanes = lanes_used;
        end
        in_req_next.last = last_item;
        in_req_next.mode = mode_reg;
    end

    assign item_stall = in_valid_reg && !sum_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_INNER;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= metric_t'(cfg_wr_data);
            end
            if (!item_stall)
            begin
                in_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_req_reg <= in_req_next;
        end
    end

    vda_item_sum u_item_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_req    (in_req_reg),
        .in_ready  (sum_ready),
        .out_valid (item_valid_s),
        .out_item  (item_s),
        .out_ready (acc_ready)
    );

    vda_accum u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (item_valid_s),
        .in_item       (item_s),
        .in_ready      (acc_ready),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .distance      (distance),
        .saturated     (saturated),
        .element_count (element_count)
    );

endmodule

// ===== rtl/core/vda_checker.sv =====
// Port-level checker for the vector distance accumulator, bound to the top level.
`timescale 1ns / 1ps
`include "vector_distance_accumulator_core_macros.svh"

module vda_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              item_stall,
    input logic                              result_valid,
    input logic                              result_stall,
    input logic signed [vda_pkg::ACC_W-1:0]  distance,
    input logic                              saturated,
    input logic [vda_pkg::CNT_W-1:0]         element_count
);
    import vda_pkg::*;

    // A stalled result keeps its payload.
    `VDA_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(distance) && $stable(saturated) && $stable(element_count), "result changed while stalled")

    `VDA_ASSERT_IMPL(a_count_bound, result_valid, element_count <= CNT_W'(MAX_DIM), "element count above maximum dimension")

    // A vector with no elements can neither sum to anything nor clip.
    `VDA_ASSERT_IMPL(a_empty_vector, result_valid && element_count == '0, distance == '0 && !saturated, "empty vector gave a nonzero result")

    // With the output free, every stage can move, so requests are never held off.
    `VDA_ASSERT_IMPL(a_no_false_stall, !result_valid || !result_stall, !item_stall, "request stalled while the output was free")

endmodule

bind vector_distance_accumulator_core vda_checker u_vda_checker (.*);

// ===== tb/distance_checker.sv =====
// Scoreboard for the vector distance accumulator: predicts every result and compares it.
`timescale 1ns / 1ps

module distance_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data,
    input  logic                                item_valid,
    input  logic                                item_stall,
    input  logic signed [vda_pkg::ELEM_W-1:0]   a_lane0,
    input  logic signed [vda_pkg::ELEM_W-1:0]   a_lane1,
    input  logic signed [vda_pkg::ELEM_W-1:0]   a_lane2,
    input  logic signed [vda_pkg::ELEM_W-1:0]   a_lane3,
    input  logic signed [vda_pkg::ELEM_W-1:0]   b_lane0,
    input  logic signed [vda_pkg::ELEM_W-1:0]   b_lane1,
    input  logic signed [vda_pkg::ELEM_W-1:0]   b_lane2,
    input  logic signed [vda_pkg::ELEM_W-1:0]   b_lane3,
    input  logic [vda_pkg::LANE_CNT_W-1:0]      lanes_used,
    input  logic                                last_item,
    input  logic                                result_valid,
    input  logic                                result_stall,
    input  logic signed [vda_pkg::ACC_W-1:0]    distance,
    input  logic                                saturated,
    input  logic [vda_pkg::CNT_W-1:0]           element_count,
    output int                                  mismatch_count,
    output int                                  results_pending
);
    import vda_pkg::*;

    typedef struct packed {
        logic signed [ACC_W-1:0] distance;
        logic                    saturated;
        logic [CNT_W-1:0]        element_count;
    } distance_result_t;

    distance_result_t        results_due[$];
    metric_t                 mode_now;
    logic signed [ACC_W-1:0] sum_acc;
    logic                    clip_seen;
    logic [CNT_W-1:0]        elems_seen;

    function automatic longint lane_term(metric_t mode, logic signed [ELEM_W-1:0] a,
                                         logic signed [ELEM_W-1:0] b);
        longint diff;
        if (mode == MODE_L2)
        begin
            diff = longint'(a) - longint'(b);
            return diff * diff;
        end
        return longint'(a) * longint'(b);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic signed [ELEM_W-1:0] a_in [IN_LANES];
        logic signed [ELEM_W-1:0] b_in [IN_LANES];
        int                       lanes;
        longint                   item_sum;
        longint                   total;
        distance_result_t         due;
        if (!rst_n)
        begin
            results_due.delete();
            mode_now        = MODE_INNER;
            sum_acc         = '0;
            clip_seen       = 1'b0;
            elems_seen      = '0;
            mismatch_count  = 0;
            results_pending = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                a_in = '{a_lane0, a_lane1, a_lane2, a_lane3};
                b_in = '{b_lane0, b_lane1, b_lane2, b_lane3};
                lanes = (int'(lanes_used) > EFF_LANES) ? EFF_LANES : int'(lanes_used);
                item_sum = 0;
                for (int i = 0; i < lanes; i++)
                    item_sum += lane_term(mode_now, a_in[i], b_in[i]);

                // The whole request is added in one step and clipped once.
                total = longint'(sum_acc) + item_sum;
                if (total > longint'(ACC_MAX))
                begin
                    sum_acc   = ACC_MAX;
                    clip_seen = 1'b1;
                end
                else if (total < longint'(ACC_MIN))
                begin
                    sum_acc   = ACC_MIN;
                    clip_seen = 1'b1;
                end
                else
                    sum_acc = total[ACC_W-1:0];

                if (int'(elems_seen) + lanes > MAX_DIM)
                    elems_seen = CNT_W'(MAX_DIM);
                else
                    elems_seen = CNT_W'(int'(elems_seen) + lanes);

                if (last_item)
                begin
                    due.distance  = sum_acc;
                    due.saturated = clip_seen;
                    // Negating the most negative sum does not fit and clips as well.
                    if (mode_now == MODE_INNER)
                    begin
                        total = -longint'(sum_acc);
                        if (total > longint'(ACC_MAX))
                        begin
                            due.distance  = ACC_MAX;
                            due.saturated = 1'b1;
                        end
                        else
                            due.distance = total[ACC_W-1:0];
                    end
                    due.element_count = elems_seen;
                    results_due.push_back(due);
                    sum_acc    = '0;
                    clip_seen  = 1'b0;
                    elems_seen = '0;
                end
            end

            if (cfg_wr_en)
                mode_now = metric_t'(cfg_wr_data);

            if (result_valid && !result_stall)
            begin
                if (results_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, distance %0d saturated %0b count %0d",
                             $time, distance, saturated, element_count);
                end
                else
                begin
                    due = results_due.pop_front();
                    if (distance !== due.distance)
                    begin
                        mismatch_count++;
                        $display("%0t: distance expected %0d, actual %0d",
                                 $time, $signed(due.distance), distance);
                    end
                    if (saturated !== due.saturated)
                    begin
                        mismatch_count++;
                        $display("%0t: saturated expected %0b, actual %0b",
                                 $time, due.saturated, saturated);
                    end
                    if (element_count !== due.element_count)
                    begin
                        mismatch_count++;
                        $display("%0t: element_count expected %0d, actual %0d",
                                 $time, due.element_count, element_count);
                    end
                end
            end

            results_pending = results_due.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the vector distance accumulator testbench: clock, reset, requests and verdict.
`timescale 1ns / 1ps

module testbench;
    import vda_pkg::*;

    localparam int IDLE_PCT      = 37;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 170;

    typedef logic [IN_LANES-1:0][ELEM_W-1:0] lane_vec_t;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     cfg_wr_en    = 1'b0;
    logic                     cfg_wr_data  = 1'b0;
    logic                     item_valid   = 1'b0;
    logic                     item_stall;
    logic signed [ELEM_W-1:0] a_lane0      = '0;
    logic signed [ELEM_W-1:0] a_lane1      = '0;
    logic signed [ELEM_W-1:0] a_lane2      = '0;
    logic signed [ELEM_W-1:0] a_lane3      = '0;
    logic signed [ELEM_W-1:0] b_lane0      = '0;
    logic signed [ELEM_W-1:0] b_lane1      = '0;
    logic signed [ELEM_W-1:0] b_lane2      = '0;
    logic signed [ELEM_W-1:0] b_lane3      = '0;
    logic [LANE_CNT_W-1:0]    lanes_used   = '0;
    logic                     last_item    = 1'b0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic signed [ACC_W-1:0]  distance;
    logic                     saturated;
    logic [CNT_W-1:0]         element_count;
    int                       mismatch_count;
    int                       results_pending;
    logic                     steady       = 1'b0;
    metric_t                  mode_set     = MODE_INNER;

    always #5 clk = ~clk;

    vector_distance_accumulator_core u_top (.*);

    distance_checker u_checker (.*);

    // The receiver stalls at random except during the steady stretch.
    always @(negedge clk)
        result_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);

    function automatic logic [ELEM_W-1:0] pick_element();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return '0;
            3:       return 16'hFFFF;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance, so valid can stay high for the next request.
    task automatic send_pairs(input lane_vec_t a, input lane_vec_t b,
                              input logic [LANE_CNT_W-1:0] lanes, input logic last);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        a_lane0    <= a[0];
        a_lane1    <= a[1];
        a_lane2    <= a[2];
        a_lane3    <= a[3];
        b_lane0    <= b[0];
        b_lane1    <= b[1];
        b_lane2    <= b[2];
        b_lane3    <= b[3];
        lanes_used <= lanes;
        last_item  <= last;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(input logic last);
        lane_vec_t             a;
        lane_vec_t             b;
        logic [LANE_CNT_W-1:0] lanes;
        for (int i = 0; i < IN_LANES; i++)
        begin
            a[i] = pick_element();
            b[i] = pick_element();
        end
        if ($urandom_range(0, 3) == 0)
            lanes = LANE_CNT_W'($urandom_range(0, 7));
        else
            lanes = LANE_CNT_W'($urandom_range(1, 4));
        send_pairs(a, b, lanes, last);
    endtask

    // Hold off requests until every result is out and the pipeline has emptied.
    task automatic drain();
        item_valid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_mode(input metric_t mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        mode_set    = mode;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin : stimulus
        int        items;
        int        vec_len;
        lane_vec_t hi;
        lane_vec_t lo;
        lane_vec_t rnd_a;
        lane_vec_t rnd_b;
        hi = {IN_LANES{16'h7FFF}};
        lo = {IN_LANES{16'h8000}};
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Inner product: zero lanes, extremes, lane counts above the width.
        set_mode(MODE_INNER);
        send_pairs('0, '0, 3'd0, 1'b1);
        send_pairs(hi, lo, 3'd4, 1'b0);
        send_pairs(lo, lo, 3'd3, 1'b1);
        send_pairs(hi, hi, 3'd7, 1'b0);
        send_pairs(lo, hi, 3'd5, 1'b1);
        rnd_a = {$urandom, $urandom};
        rnd_b = {$urandom, $urandom};
        send_pairs(rnd_a, rnd_b, 3'd1, 1'b0);
        send_pairs(rnd_b, rnd_a, 3'd2, 1'b0);
        send_pairs(rnd_a, rnd_a, 3'd6, 1'b1);
        send_pairs(lo, hi, 3'd4, 1'b1);
        drain();

        // Squared distance with the largest differences, zero lanes and random elements.
        set_mode(MODE_L2);
        send_pairs(hi, lo, 3'd4, 1'b1);
        send_pairs(lo, hi, 3'd4, 1'b0);
        send_pairs('0, '0, 3'd0, 1'b1);
        send_pairs(rnd_a, rnd_b, 3'd3, 1'b1);

        // Mode flips in the middle of a vector, both ways.
        send_pairs(hi, lo, 3'd2, 1'b0);
        drain();
        set_mode(MODE_INNER);
        send_pairs(hi, lo, 3'd2, 1'b1);
        send_pairs(hi, lo, 3'd4, 1'b0);
        drain();
        set_mode(MODE_L2);
        send_pairs(rnd_b, rnd_a, 3'd4, 1'b1);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                set_mode(MODE_L2);
            else if (phase == 1)
                set_mode(MODE_INNER);
            else
                set_mode(metric_t'($urandom_range(0, 1)));
            steady <= (phase == 1);
            items = 0;
            while (items < PHASE_ITEMS)
            begin
                vec_len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
                                                      : $urandom_range(1, 5);
                for (int k = 1; k <= vec_len; k++)
                begin
                    if (k > 1 && $urandom_range(0, 19) == 0)
                    begin
                        drain();
                        set_mode(mode_set == MODE_L2 ? MODE_INNER : MODE_L2);
                    end
                    send_random(k == vec_len);
                    items++;
                end
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/vda_pkg.sv
rtl/core/vda_item_sum.sv
rtl/core/vda_accum.sv
rtl/core/vector_distance_accumulator_core.sv
rtl/core/vda_checker.sv
tb/distance_checker.sv
tb/testbench.sv
